// ===== hdl/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg
// Shared constants, register indexes and unit command type for the ADC
// frame statistics block.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int CODE_BITS     = 12;
  localparam int MAX_FRAME_DEF = 4096;
  localparam int FRAME_LEN_W   = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int Q8_W          = 20;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_HIGH    = 2'd2;

  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 13'd1024;
  localparam logic [CODE_BITS-1:0]   CLIP_LOW_RESET  = 12'd24;
  localparam logic [CODE_BITS-1:0]   CLIP_HIGH_RESET = 12'd4071;

  typedef logic [1:0] afs_op_t;

  localparam afs_op_t OP_DIV  = 2'd0;
  localparam afs_op_t OP_SQRT = 2'd1;
  localparam afs_op_t OP_MUL  = 2'd2;

  typedef struct packed {
    logic    go;
    afs_op_t op;
  } afs_cmd_t;

endpackage

// ===== hdl/afs_arith.sv =====
// ----------------------------------------------------------------------------
// afs_arith
// Shared iterative arithmetic unit: restoring divide, digit-by-digit square
// root and shift-add multiply, one bit (one root digit) per cycle on a
// single shared adder.
// ----------------------------------------------------------------------------
module afs_arith
  import afs_pkg::*;
#(
  parameter int XW = 66,
  parameter int YW = 37
) (
  input  logic          clk,
  input  logic          rst,
  input  afs_cmd_t      cmd,
  input  logic [XW-1:0] a,
  input  logic [YW-1:0] b,
  output logic [XW-1:0] result,
  output logic          done
);

  localparam int AW = XW + 1;
  localparam int RW = XW / 2;
  localparam int CW = $clog2(XW + 1);

  afs_op_t       op;
  logic [XW-1:0] x;
  logic [YW-1:0] y;
  logic [AW-1:0] acc;
  logic [RW-1:0] root;
  logic [CW-1:0] cnt;
  logic          run;

  logic [AW-1:0] opa;
  logic [AW-1:0] opb;
  logic          sub;
  logic [AW:0]   sum;
  logic          ge;

  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b1;
    unique case (op)
      OP_DIV: begin
        opa = {acc[AW-2:0], x[XW-1]};
        opb = AW'(y);
      end
      OP_SQRT: begin
        opa = {acc[AW-3:0], x[XW-1:XW-2]};
        opb = AW'({root, 2'b01});
      end
      OP_MUL: begin
        opa = {acc[AW-2:0], 1'b0};
        opb = x[XW-1] ? AW'(y) : '0;
        sub = 1'b0;
      end
      default: ;
    endcase
    sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (AW + 1)'(sub);
  end

  assign ge = sum[AW];

  always_comb begin
    unique case (op)
      OP_DIV:  result = x;
      OP_SQRT: result = XW'(root);
      OP_MUL:  result = acc[XW-1:0];
      default: result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        run <= 1'b1;
        cnt <= (cmd.op == OP_SQRT) ? CW'(RW) : CW'(XW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      op   <= cmd.op;
      x    <= a;
      y    <= b;
      acc  <= '0;
      root <= '0;
    end else if (run) begin
      unique case (op)
        OP_DIV: begin
          acc <= ge ? sum[AW-1:0] : opa;
          x   <= {x[XW-2:0], ge};
        end
        OP_SQRT: begin
          acc  <= ge ? sum[AW-1:0] : opa;
          root <= {root[RW-2:0], ge};
          x    <= {x[XW-3:0], 2'b00};
        end
        OP_MUL: begin
          acc <= sum[AW-1:0];
          x   <= {x[XW-2:0], 1'b0};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/adc_frame_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// adc_frame_statistics_unit
// Per-frame mean, min, max, peak-to-peak, RMS and AC RMS of ADC codes, and a clip flag.
// ----------------------------------------------------------------------------
// Samples are absorbed at one beat per cycle; busy stays low within a frame.
// The beat that closes a frame raises busy while the shared arithmetic unit
// runs eight one-bit-per-cycle operations in turn; the result then shows with
// valid for one cycle, as busy falls. Synchronous reset restores register
// defaults and clears all accumulators.
module adc_frame_statistics_unit
  import afs_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CODE_BITS-1:0]  sample_code,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  valid,
  output logic [Q8_W-1:0]       mean_q8,
  output logic [CODE_BITS-1:0]  min_code,
  output logic [CODE_BITS-1:0]  max_code,
  output logic [CODE_BITS-1:0]  peak_to_peak,
  output logic [Q8_W-1:0]       rms_q8,
  output logic [Q8_W-1:0]       ac_rms_q8,
  output logic                  clipped
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int SUM_W = CODE_BITS + CNT_W;
  localparam int SQ_W  = 2 * CODE_BITS + CNT_W;
  localparam int PW    = CNT_W + SQ_W;
  localparam int XW    = PW + 16 + (PW % 2);
  localparam int YW    = SQ_W;
  localparam int CMP_W = (FRAME_LEN_W > CNT_W) ? FRAME_LEN_W : CNT_W;

  localparam logic [3:0] ST_ACC      = 4'd0;
  localparam logic [3:0] ST_MEAN     = 4'd1;
  localparam logic [3:0] ST_RMS_DIV  = 4'd2;
  localparam logic [3:0] ST_RMS_SQRT = 4'd3;
  localparam logic [3:0] ST_MUL_NQ   = 4'd4;
  localparam logic [3:0] ST_MUL_SS   = 4'd5;
  localparam logic [3:0] ST_AC_DIV1  = 4'd6;
  localparam logic [3:0] ST_AC_DIV2  = 4'd7;
  localparam logic [3:0] ST_AC_SQRT  = 4'd8;

  logic [3:0]             state;
  logic                   launch;
  logic [FRAME_LEN_W-1:0] frame_length;
  logic [CODE_BITS-1:0]   clip_low_code;
  logic [CODE_BITS-1:0]   clip_high_code;

  logic [CNT_W-1:0]       sample_count;
  logic [SUM_W-1:0]       code_sum;
  logic [SQ_W-1:0]        square_sum;
  logic [CODE_BITS-1:0]   running_min;
  logic [CODE_BITS-1:0]   running_max;
  logic                   clip_seen;

  logic [PW-1:0]          prod;
  logic [XW-1:0]          tmp;

  logic                   accept;
  logic [CNT_W-1:0]       count_inc;
  logic [CMP_W-1:0]       len_raw;
  logic [CMP_W-1:0]       len_eff;
  logic                   last;
  logic [2*CODE_BITS-1:0] code_sq;

  afs_cmd_t               cmd;
  logic [XW-1:0]          op_a;
  logic [YW-1:0]          op_b;
  logic [XW-1:0]          u_result;
  logic                   u_done;
  logic [PW-1:0]          u_prod;

  assign busy      = (state != ST_ACC);
  assign accept    = start && !busy;
  assign count_inc = sample_count + 1'b1;
  assign len_raw   = CMP_W'(frame_length);
  assign code_sq   = sample_code * sample_code;
  assign u_prod    = u_result[PW-1:0];

  always_comb begin
    if (len_raw < CMP_W'(2)) begin
      len_eff = CMP_W'(2);
    end else if (len_raw > CMP_W'(MAX_FRAME)) begin
      len_eff = CMP_W'(MAX_FRAME);
    end else begin
      len_eff = len_raw;
    end
  end

  assign last = CMP_W'(count_inc) >= len_eff;

  always_comb begin
    cmd.go = launch;
    cmd.op = OP_DIV;
    op_a   = '0;
    op_b   = YW'(sample_count);
    unique case (state)
      ST_MEAN:     op_a = XW'({code_sum, 8'h00});
      ST_RMS_DIV:  op_a = XW'({square_sum, 16'h0000});
      ST_RMS_SQRT: begin
        cmd.op = OP_SQRT;
        op_a   = tmp;
      end
      ST_MUL_NQ: begin
        cmd.op = OP_MUL;
        op_a   = XW'(sample_count);
        op_b   = square_sum;
      end
      ST_MUL_SS: begin
        cmd.op = OP_MUL;
        op_a   = XW'(code_sum);
        op_b   = YW'(code_sum);
      end
      ST_AC_DIV1:  op_a = XW'({prod, 16'h0000});
      ST_AC_DIV2:  op_a = tmp;
      ST_AC_SQRT: begin
        cmd.op = OP_SQRT;
        op_a   = tmp;
      end
      default: ;
    endcase
  end

  afs_arith #(
    .XW(XW),
    .YW(YW)
  ) u_arith (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .a     (op_a),
    .b     (op_b),
    .result(u_result),
    .done  (u_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_ACC;
      launch         <= 1'b0;
      valid          <= 1'b0;
      frame_length   <= FRAME_LEN_RESET;
      clip_low_code  <= CLIP_LOW_RESET;
      clip_high_code <= CLIP_HIGH_RESET;
      sample_count   <= '0;
      code_sum       <= '0;
      square_sum     <= '0;
      running_min    <= '1;
      running_max    <= '0;
      clip_seen      <= 1'b0;
    end else begin
      launch <= 1'b0;
      valid  <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_FRAME_LENGTH: frame_length   <= wr_data[FRAME_LEN_W-1:0];
          REG_CLIP_LOW:     clip_low_code  <= wr_data[CODE_BITS-1:0];
          REG_CLIP_HIGH:    clip_high_code <= wr_data[CODE_BITS-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_ACC: begin
          if (accept) begin
            sample_count <= count_inc;
            code_sum     <= code_sum + SUM_W'(sample_code);
            square_sum   <= square_sum + SQ_W'(code_sq);
            if (sample_code < running_min) begin
              running_min <= sample_code;
            end
            if (sample_code > running_max) begin
              running_max <= sample_code;
            end
            if (sample_code <= clip_low_code || sample_code >= clip_high_code) begin
              clip_seen <= 1'b1;
            end
            if (last) begin
              state  <= ST_MEAN;
              launch <= 1'b1;
            end
          end
        end
        ST_MEAN, ST_RMS_DIV, ST_RMS_SQRT, ST_MUL_NQ, ST_MUL_SS, ST_AC_DIV1,
        ST_AC_DIV2: begin
          if (u_done) begin
            state  <= state + 4'd1;
            launch <= 1'b1;
          end
        end
        ST_AC_SQRT: begin
          if (u_done) begin
            state        <= ST_ACC;
            valid        <= 1'b1;
            sample_count <= '0;
            code_sum     <= '0;
            square_sum   <= '0;
            running_min  <= '1;
            running_max  <= '0;
            clip_seen    <= 1'b0;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (u_done) begin
      unique case (state)
        ST_MEAN:     mean_q8 <= u_result[Q8_W-1:0];
        ST_RMS_DIV:  tmp     <= u_result;
        ST_RMS_SQRT: rms_q8  <= u_result[Q8_W-1:0];
        ST_MUL_NQ:   prod    <= u_prod;
        ST_MUL_SS:   prod    <= (prod > u_prod) ? prod - u_prod : '0;
        ST_AC_DIV1:  tmp     <= u_result;
        ST_AC_DIV2:  tmp     <= u_result;
        ST_AC_SQRT: begin
          ac_rms_q8    <= u_result[Q8_W-1:0];
          min_code     <= running_min;
          max_code     <= running_max;
          peak_to_peak <= running_max - running_min;
          clipped      <= clip_seen;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/afs_checker.sv =====
// ----------------------------------------------------------------------------
// afs_checker
// Port-level checks on the result beat and busy timing of the frame
// statistics block.
// ----------------------------------------------------------------------------
module afs_checker
  import afs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 valid,
  input logic [CODE_BITS-1:0] min_code,
  input logic [CODE_BITS-1:0] max_code,
  input logic [CODE_BITS-1:0] peak_to_peak,
  input logic [Q8_W-1:0]      rms_q8,
  input logic [Q8_W-1:0]      ac_rms_q8
);

  // busy only rises after a sample beat
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a sample beat");

  // the frame computation ends exactly with a result beat
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> valid)
    else $error("busy fell without a result beat");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("two result beats in a row");

  a_result_consistent: assert property (@(posedge clk) disable iff (rst)
    valid |-> (min_code <= max_code) && (ac_rms_q8 <= rms_q8) &&
              (peak_to_peak == CODE_BITS'(max_code - min_code)))
    else $error("inconsistent result fields");

endmodule

bind adc_frame_statistics_unit afs_checker u_afs_checker (.*);
